@@ src/difficulty_retarget_compact_core_assert.svh @@
// assertion macros for the core rtl file
`ifndef DIFFICULTY_RETARGET_COMPACT_CORE_ASSERT_SVH
`define DIFFICULTY_RETARGET_COMPACT_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define DRC_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define DRC_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/drc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package drc_pkg;

    localparam int TARGET_BITS_DEF = 256;

    // divider dividend width and bits retired per stage
    localparam int DVW        = 72;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DVW / DIV_STEP;
    localparam int LW         = 7;

    localparam logic [15:0] SPACING_RST   = 16'd600;
    localparam logic [31:0] LIMIT_RST     = 32'h1e0fffff;
    localparam logic [31:0] FLOOR_COMPACT = 32'h1e0fffff;

    // register index, taken from paddr[2]
    localparam logic REG_SPACING = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    typedef struct packed {
        logic [22:0] mm;
        logic [7:0]  shb;
        logic        sat;
        logic        nz;
        logic        neg;
    } dec_t;

    typedef struct packed {
        logic [7:0]  jb;
        logic        gt;
        logic        lt;
        logic        vsign;
        logic        lsign;
        logic [31:0] lim_word;
    } meta_t;

    function automatic logic [LW-1:0] bit_len(input logic [DVW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < DVW; i++)
        begin
            if (v[i])
            begin
                n = LW'(i + 1);
            end
        end
        return n;
    endfunction

    // compact word to mantissa, byte shift and saturation flag
    function automatic dec_t decode(input logic [31:0] c, input int tb);
        dec_t d;
        logic [7:0]  size;
        logic [22:0] m;
        logic [4:0]  mlen;
        size  = c[31:24];
        m     = c[22:0];
        mlen  = 5'(bit_len(DVW'(m)));
        d.shb = '0;
        d.sat = 1'b0;
        case (size)
            8'd0:    d.mm = '0;
            8'd1:    d.mm = m >> 16;
            8'd2:    d.mm = m >> 8;
            8'd3:    d.mm = m;
            default:
            begin
                d.mm  = m;
                d.shb = size - 8'd3;
                d.sat = (m != '0) && (({7'b0, mlen} + {1'b0, d.shb, 3'b000}) > 12'(tb));
            end
        endcase
        d.nz  = d.sat || (d.mm != '0);
        d.neg = c[23] && d.nz;
        return d;
    endfunction

    // compact encoding of v * 2^(8*jb), sign bit left clear; a zero value
    // encodes with a zero byte count whatever the offset
    function automatic logic [31:0] encode_word(input logic [DVW-1:0] v,
                                                input logic [LW-1:0]  len,
                                                input logic [7:0]     jb);
        logic [3:0]  nb0;
        logic [23:0] w;
        logic [7:0]  nb;
        nb0 = 4'((8'(len) + 8'd7) >> 3);
        if (nb0 <= 4'd3)
        begin
            w = v[23:0] << {3'(4'd3 - nb0), 3'b000};
        end
        else
        begin
            w = 24'(v >> {4'(nb0 - 4'd3), 3'b000});
        end
        nb = (len == '0) ? 8'd0 : 8'(nb0) + jb;
        if (w[23])
        begin
            w  = {8'b0, w[23:8]};
            nb = nb + 8'd1;
        end
        return {nb, 1'b0, w[22:0]};
    endfunction

endpackage

`default_nettype wire

@@ src/drc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, DIV_STEP quotient bits per stage
module drc_div
    import drc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [DIV_STAGES-1:0] en,
    input  wire logic [15:0]           divisor,
    input  wire logic [DVW-1:0]        dividend,
    input  wire meta_t                 in_meta,
    output logic      [DVW-1:0]        quotient,
    output meta_t                      out_meta
);

    logic [DVW-1:0] acc_reg  [DIV_STAGES];
    logic [15:0]    rem_reg  [DIV_STAGES];
    meta_t          meta_reg [DIV_STAGES];
    logic [DVW-1:0] acc_next [DIV_STAGES];
    logic [15:0]    rem_next [DIV_STAGES];

    always_comb
    begin
        logic [DVW-1:0] a;
        logic [15:0]    r;
        logic [16:0]    t;
        logic           ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                a = dividend;
                r = '0;
            end
            else
            begin
                a = acc_reg[s-1];
                r = rem_reg[s-1];
            end
            for (int k = 0; k < DIV_STEP; k++)
            begin
                t  = {r, a[DVW-1]};
                ge = (t >= {1'b0, divisor});
                r  = ge ? 16'(t - {1'b0, divisor}) : t[15:0];
                a  = {a[DVW-2:0], ge};
            end
            acc_next[s] = a;
            rem_next[s] = r;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                acc_reg[s]  <= acc_next[s];
                rem_reg[s]  <= rem_next[s];
                meta_reg[s] <= (s == 0) ? in_meta : meta_reg[s-1];
            end
        end
    end

    assign quotient = acc_reg[DIV_STAGES-1];
    assign out_meta = meta_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ src/difficulty_retarget_compact_core.sv @@
// pipeline: input beat to result beat through 4 front stages, 18 divider
// stages of 4 quotient bits each and 3 encode stages
// throughput: one beat per cycle; a stalled output freezes only full stages,
// bubbles close up so input keeps flowing until every stage holds a beat
// reset: rst_n clears all valid bits and loads spacing 600 and limit 0x1e0fffff
`timescale 1ns / 1ps
`default_nettype none

module difficulty_retarget_compact_core
    import drc_pkg::*;
#(
    parameter int TARGET_BITS = TARGET_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // last_bits, last_time, prev_time
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // new_bits
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

`include "difficulty_retarget_compact_core_assert.svh"

    // product is at most TARGET_BITS + 17 bits wide, one spare
    localparam int PW    = TARGET_BITS + 18;
    localparam int LPW   = $clog2(PW + 1);
    localparam int NSTG  = 4 + DIV_STAGES + 3;
    localparam int ST_D  = 3;
    localparam int ST_E1 = 4 + DIV_STAGES;
    localparam int ST_E2 = ST_E1 + 1;
    localparam int ST_E3 = ST_E1 + 2;
    // saturated limit as a short run of ones plus a byte offset
    localparam int JLB   = (TARGET_BITS - 40) / 8;
    localparam logic [DVW-1:0] SAT_LIM_V = (DVW'(1) << (TARGET_BITS - 8 * JLB)) - DVW'(1);

    // ---------------- configuration registers ----------------
    logic [15:0] spacing_reg;
    logic [31:0] limit_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RST;
            limit_reg   <= LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_SPACING: spacing_reg <= pwdata[15:0];
                REG_LIMIT:   limit_reg   <= pwdata;
                default:     limit_reg   <= limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SPACING: prdata = {16'b0, spacing_reg};
            REG_LIMIT:   prdata = limit_reg;
            default:     prdata = '0;
        endcase
    end

    // ---------------- stage valid bits and advance ----------------
    // a stage loads when it is empty or its successor loads
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_axis_tready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        for (int i = 0; i < NSTG; i++)
        begin
            if (!en[i])
            begin
                v_next[i] = v_reg[i];
            end
            else if (i == 0)
            begin
                v_next[i] = s_axis_tvalid;
            end
            else
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[ST_E3];

    // ---------------- stage a: clamp timespan, decode both targets ----------------
    logic [33:0] a_dt;
    logic [16:0] a_lo;
    logic [16:0] a_hi;
    logic [16:0] a_span_next;
    logic [16:0] a_span_reg;
    dec_t        a_vd_reg;
    dec_t        a_ld_reg;

    always_comb
    begin
        a_dt = {2'b00, s_axis_tdata[63:32]} - {2'b00, s_axis_tdata[95:64]};
        a_lo = {1'b0, spacing_reg - {2'b00, spacing_reg[15:2]}};
        a_hi = {1'b0, spacing_reg} + {2'b00, spacing_reg[15:1]};
        if ($signed(a_dt) < $signed({17'b0, a_lo}))
        begin
            a_span_next = a_lo;
        end
        else if ($signed(a_dt) > $signed({17'b0, a_hi}))
        begin
            a_span_next = a_hi;
        end
        else
        begin
            a_span_next = a_dt[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_span_reg <= a_span_next;
            a_vd_reg   <= decode(s_axis_tdata[31:0], TARGET_BITS);
            a_ld_reg   <= decode(limit_reg, TARGET_BITS);
        end
    end

    // ---------------- stage b: mantissa products ----------------
    logic [39:0] b_x_reg;   // mantissa * timespan
    logic [38:0] b_lx_reg;  // limit mantissa * spacing
    logic [16:0] b_span_reg;
    dec_t        b_vd_reg;
    dec_t        b_ld_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_x_reg    <= 40'(a_vd_reg.mm) * 40'(a_span_reg);
            b_lx_reg   <= 39'(a_ld_reg.mm) * 39'(spacing_reg);
            b_span_reg <= a_span_reg;
            b_vd_reg   <= a_vd_reg;
            b_ld_reg   <= a_ld_reg;
        end
    end

    // ---------------- stage c: place products at full width ----------------
    // p = target * timespan, ls = limit * spacing; a saturated target is
    // all ones, so its product is span * 2^bits - span
    logic [PW-1:0]  c_p_next;
    logic [PW-1:0]  c_ls_next;
    logic [11:0]    c_lp_wide;
    logic [DVW-1:0] c_lim_v;
    logic [7:0]     c_lim_off;
    logic [PW-1:0]  c_p_reg;
    logic [PW-1:0]  c_ls_reg;
    logic [LPW-1:0] c_lp_reg;
    logic           c_vneg_reg;
    logic           c_lneg_reg;
    logic           c_lnz_reg;
    logic [31:0]    c_limw_reg;

    always_comb
    begin
        if (b_vd_reg.sat)
        begin
            c_p_next = (PW'(b_span_reg) << TARGET_BITS) - PW'(b_span_reg);
        end
        else
        begin
            c_p_next = PW'(b_x_reg) << {b_vd_reg.shb, 3'b000};
        end
        if (b_ld_reg.sat)
        begin
            c_ls_next = (PW'(spacing_reg) << TARGET_BITS) - PW'(spacing_reg);
        end
        else
        begin
            c_ls_next = PW'(b_lx_reg) << {b_ld_reg.shb, 3'b000};
        end
        // length of p, exact or one too long when saturated
        if (b_x_reg == '0)
        begin
            c_lp_wide = '0;
        end
        else if (b_vd_reg.sat)
        begin
            c_lp_wide = 12'(TARGET_BITS) + 12'(bit_len(DVW'(b_span_reg)));
        end
        else
        begin
            c_lp_wide = 12'(bit_len(DVW'(b_x_reg))) + {1'b0, b_vd_reg.shb, 3'b000};
        end
        c_lim_v   = b_ld_reg.sat ? SAT_LIM_V : DVW'(b_ld_reg.mm);
        c_lim_off = b_ld_reg.sat ? 8'(JLB) : b_ld_reg.shb;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_p_reg    <= c_p_next;
            c_ls_reg   <= c_ls_next;
            c_lp_reg   <= LPW'(c_lp_wide);
            c_vneg_reg <= b_vd_reg.neg;
            c_lneg_reg <= b_ld_reg.neg;
            c_lnz_reg  <= b_ld_reg.nz;
            c_limw_reg <= encode_word(c_lim_v, bit_len(c_lim_v), c_lim_off)
                          | {8'b0, b_ld_reg.neg, 23'b0};
        end
    end

    // ---------------- stage d: limit compare, window for the divider ----------------
    // floor(p/s) > lim  <=>  p - lim*s >= s ;  floor(p/s) < lim  <=>  p < lim*s
    // top bits of floor(p/s) come exactly from floor((p >> j)/s), j byte aligned
    logic [PW:0]    d_diff;
    logic [7:0]     d_jb;
    logic           d_snz;
    meta_t          d_meta_next;
    logic [DVW-1:0] d_pj_reg;
    meta_t          d_meta_reg;

    always_comb
    begin
        d_diff = {1'b0, c_p_reg} - {1'b0, c_ls_reg};
        d_snz  = (spacing_reg != '0);
        if (c_lp_reg > LPW'(DVW))
        begin
            d_jb = 8'((c_lp_reg - LPW'(DVW) + LPW'(7)) >> 3);
        end
        else
        begin
            d_jb = '0;
        end
        d_meta_next.jb       = d_jb;
        d_meta_next.gt       = d_snz && !d_diff[PW] && (d_diff[PW-1:0] >= PW'(spacing_reg));
        d_meta_next.lt       = d_snz ? d_diff[PW] : c_lnz_reg;
        d_meta_next.vsign    = c_vneg_reg;
        d_meta_next.lsign    = c_lneg_reg;
        d_meta_next.lim_word = c_limw_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_D])
        begin
            d_pj_reg   <= DVW'(c_p_reg >> {d_jb, 3'b000});
            d_meta_reg <= d_meta_next;
        end
    end

    // ---------------- divider by target spacing ----------------
    logic [DVW-1:0] q_div;
    meta_t          q_meta;

    drc_div u_div
    (
        .clk      (clk),
        .en       (en[ST_E1-1:ST_D+1]),
        .divisor  (spacing_reg),
        .dividend (d_pj_reg),
        .in_meta  (d_meta_reg),
        .quotient (q_div),
        .out_meta (q_meta)
    );

    // ---------------- stage e1: quotient length ----------------
    // zero spacing means a zero value, no division
    logic [DVW-1:0] e1_qv;
    logic [DVW-1:0] e1_q_reg;
    logic [LW-1:0]  e1_len_reg;
    meta_t          e1_meta_reg;

    assign e1_qv = (spacing_reg != '0) ? q_div : '0;

    always_ff @(posedge clk)
    begin
        if (en[ST_E1])
        begin
            e1_q_reg    <= e1_qv;
            e1_len_reg  <= bit_len(e1_qv);
            e1_meta_reg <= q_meta;
        end
    end

    // ---------------- stage e2: encode, apply the limit cap ----------------
    logic        e2_vneg;
    logic        e2_cap;
    logic [31:0] e2_word;
    logic [31:0] e2_word_reg;

    always_comb
    begin
        // a zero value counts as non-negative
        e2_vneg = e1_meta_reg.vsign && (e1_len_reg != '0);
        if (e2_vneg != e1_meta_reg.lsign)
        begin
            e2_cap = e1_meta_reg.lsign;
        end
        else if (e2_vneg)
        begin
            e2_cap = e1_meta_reg.lt;
        end
        else
        begin
            e2_cap = e1_meta_reg.gt;
        end
        if (e2_cap)
        begin
            e2_word = e1_meta_reg.lim_word;
        end
        else
        begin
            e2_word = encode_word(e1_q_reg, e1_len_reg, e1_meta_reg.jb)
                      | {8'b0, e2_vneg, 23'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_E2])
        begin
            e2_word_reg <= e2_word;
        end
    end

    // ---------------- stage e3: ceiling on the compact word, output ----------------
    logic [31:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_E3])
        begin
            out_reg <= (e2_word_reg > FLOOR_COMPACT) ? FLOOR_COMPACT : e2_word_reg;
        end
    end

    assign m_axis_tdata = out_reg;

    // ---------------- assertions ----------------
    `DRC_ASSERT_NOW(a_out_ceiling, m_axis_tvalid, m_axis_tdata <= FLOOR_COMPACT,
        "result above compact ceiling")
    `DRC_ASSERT_NOW(a_stall_full, !s_axis_tready, &v_reg,
        "input held off while a stage is empty")
    `DRC_ASSERT_NXT(a_spacing_wr, cfg_wr && (paddr[2] == REG_SPACING),
        spacing_reg == $past(pwdata[15:0]), "spacing write lost")

endmodule

`default_nettype wire
